// ===== hdl/tcm_pkg.sv =====
`timescale 1ns / 1ps
package tcm_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int NODES       = 10;
  localparam int POINTS      = 4;
  localparam int ENTRIES     = 55;
  localparam int JAC_DEPTH   = 36;
  localparam int JAC_W       = 48;
  localparam int JAC_AW      = 6;
  localparam int PT_STRIDE   = 9;
  localparam int DSH_W       = 32;
  localparam int K_W         = 40;
  localparam int FRAC        = 28;
  localparam int PROD_W      = DSH_W + COORD_WIDTH;
  localparam int DET_STEPS   = 9;
  localparam int MUL_DIGIT   = 4;
  localparam int MUL_STEPS   = 64 / MUL_DIGIT;
  localparam int QDEPTH      = 2;
  localparam int QPTR        = 1;

  localparam logic [31:0] DENSITY_RESET = 32'd65536;

  localparam longint unsigned FIVE15 = 64'd30517578125;
  localparam longint QA =
    longint'((64'd585410196627215 * 64'd8192 + FIVE15 / 2) / FIVE15);
  localparam longint QB =
    longint'((64'd138196601125011 * 64'd8192 + FIVE15 / 2) / FIVE15);
  localparam longint ONE_Q  = longint'(1) <<< FRAC;
  localparam longint K_DIV  = 64'sd1572864;
  localparam longint K_HALF = 64'sd786432;

  // Jacobian entry offsets within one point (row = d, column = c)
  localparam logic [3:0] J00 = 4'd0, J01 = 4'd1, J02 = 4'd2;
  localparam logic [3:0] J10 = 4'd3, J11 = 4'd4, J12 = 4'd5;
  localparam logic [3:0] J20 = 4'd6, J21 = 4'd7, J22 = 4'd8;
  localparam logic [3:0] M0 = 4'd0, M1 = 4'd1, M2 = 4'd2;

  typedef logic signed [DSH_W-1:0] dsh_t;
  typedef dsh_t [POINTS-1:0][2:0][NODES-1:0] dsh_tab_t;
  typedef logic signed [K_W-1:0] kc_t;
  typedef kc_t [ENTRIES-1:0][POINTS-1:0] k_tab_t;

  typedef struct packed {
    logic                          node_ok;
    logic [3:0]                    node;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          last;
  } item_t;

  typedef enum logic [1:0] {OP_LOAD, OP_ADD, OP_SUB} acc_op_t;
  typedef enum logic [1:0] {FIN_NONE, FIN_MINOR, FIN_DET} fin_t;

  typedef struct packed {
    logic [3:0] a_idx;
    logic       b_minor;
    logic [3:0] b_idx;
    acc_op_t    op;
    fin_t       fin;
  } det_step_t;

  typedef enum logic [3:0] {
    B_IDLE, B_ACC_RD, B_ACC_WR, B_RD_A, B_RD_B, B_OPS, B_MUL, B_WAIT, B_ACCUM, B_FIN
  } back_state_t;

  typedef enum logic [1:0] {PH_DET, PH_SUM, PH_DENS} phase_t;

  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic dsh_tab_t build_dsh();
    dsh_tab_t t;
    longint   r, s, u, l1, l2, l3, l4;
    int       p;
    t = '0;
    for (p = 0; p < POINTS; p++) begin
      r  = (p == 0) ? QA : QB;
      s  = (p == 1) ? QA : QB;
      u  = (p == 2) ? QA : QB;
      l1 = ONE_Q - r - s - u;
      l2 = r;
      l3 = s;
      l4 = u;
      t[p][0][0] = DSH_W'(ONE_Q - 4 * l1);
      t[p][1][0] = DSH_W'(ONE_Q - 4 * l1);
      t[p][2][0] = DSH_W'(ONE_Q - 4 * l1);
      t[p][0][1] = DSH_W'(4 * l2 - ONE_Q);
      t[p][1][2] = DSH_W'(4 * l3 - ONE_Q);
      t[p][2][3] = DSH_W'(4 * l4 - ONE_Q);
      t[p][0][4] = DSH_W'(4 * (l1 - l2));
      t[p][1][4] = DSH_W'(-4 * l2);
      t[p][2][4] = DSH_W'(-4 * l2);
      t[p][0][5] = DSH_W'(4 * l3);
      t[p][1][5] = DSH_W'(4 * l2);
      t[p][0][6] = DSH_W'(-4 * l3);
      t[p][1][6] = DSH_W'(4 * (l1 - l3));
      t[p][2][6] = DSH_W'(-4 * l3);
      t[p][0][7] = DSH_W'(-4 * l4);
      t[p][1][7] = DSH_W'(-4 * l4);
      t[p][2][7] = DSH_W'(4 * (l1 - l4));
      t[p][0][8] = DSH_W'(4 * l4);
      t[p][2][8] = DSH_W'(4 * l2);
      t[p][1][9] = DSH_W'(4 * l4);
      t[p][2][9] = DSH_W'(4 * l3);
    end
    return t;
  endfunction

  // N_i*N_j/24 in Q.40, upper triangle in row-major order
  function automatic k_tab_t build_k();
    k_tab_t t;
    longint r, s, u, l1, l2, l3, l4, prod, mag, q;
    longint nv [NODES];
    int     p, i, j, e;
    t = '0;
    for (p = 0; p < POINTS; p++) begin
      r  = (p == 0) ? QA : QB;
      s  = (p == 1) ? QA : QB;
      u  = (p == 2) ? QA : QB;
      l1 = ONE_Q - r - s - u;
      l2 = r;
      l3 = s;
      l4 = u;
      nv[0] = qmul(l1, 2 * l1 - ONE_Q);
      nv[1] = qmul(l2, 2 * l2 - ONE_Q);
      nv[2] = qmul(l3, 2 * l3 - ONE_Q);
      nv[3] = qmul(l4, 2 * l4 - ONE_Q);
      nv[4] = qmul(4 * l1, l2);
      nv[5] = qmul(4 * l2, l3);
      nv[6] = qmul(4 * l3, l1);
      nv[7] = qmul(4 * l1, l4);
      nv[8] = qmul(4 * l2, l4);
      nv[9] = qmul(4 * l3, l4);
      e = 0;
      for (i = 0; i < NODES; i++) begin
        for (j = i; j < NODES; j++) begin
          prod = nv[i] * nv[j];
          mag  = (prod < 0) ? -prod : prod;
          q    = (mag + K_HALF) / K_DIV;
          t[e][p] = K_W'((prod < 0) ? -q : q);
          e++;
        end
      end
    end
    return t;
  endfunction

  localparam dsh_tab_t DSH  = build_dsh();
  localparam k_tab_t   KTAB = build_k();

  // round half up, shift right by n, saturate to 64 bits
  function automatic logic signed [63:0] rsat(input logic signed [127:0] v, input int n);
    logic signed [127:0] t;
    t = (v + (128'sd1 <<< (n - 1))) >>> n;
    if ((t[127:63] == '0) || (t[127:63] == '1)) begin
      return t[63:0];
    end
    return t[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic det_step_t det_step(input logic [3:0] step);
    det_step_t s;
    case (step)
      4'd0:    s = '{J11, 1'b0, J22, OP_LOAD, FIN_NONE};
      4'd1:    s = '{J12, 1'b0, J21, OP_SUB,  FIN_MINOR};
      4'd2:    s = '{J10, 1'b0, J22, OP_LOAD, FIN_NONE};
      4'd3:    s = '{J12, 1'b0, J20, OP_SUB,  FIN_MINOR};
      4'd4:    s = '{J10, 1'b0, J21, OP_LOAD, FIN_NONE};
      4'd5:    s = '{J11, 1'b0, J20, OP_SUB,  FIN_MINOR};
      4'd6:    s = '{J00, 1'b1, M0,  OP_LOAD, FIN_NONE};
      4'd7:    s = '{J01, 1'b1, M1,  OP_SUB,  FIN_NONE};
      4'd8:    s = '{J02, 1'b1, M2,  OP_ADD,  FIN_DET};
      default: s = '{J00, 1'b0, J00, OP_LOAD, FIN_NONE};
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/tcm_queue.sv =====
`timescale 1ns / 1ps
module tcm_queue import tcm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  input  logic  pop,
  output item_t dout,
  output logic  full,
  output logic  empty
);

  item_t           slots [QDEPTH];
  logic [QPTR-1:0] wp, rp;
  logic [QPTR:0]   count;

  assign full  = (count == (QPTR + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
  end

endmodule

// ===== hdl/tcm_mul.sv =====
`timescale 1ns / 1ps
module tcm_mul import tcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [63:0]   a,
  input  logic signed [63:0]   b,
  output logic                 done,
  output logic signed [127:0]  prod
);

  logic                 run, fin, neg;
  logic [3:0]           cnt;
  logic [63:0]          ua, ub;
  logic [127:0]         acc;
  logic [67:0]          pp;

  // radix-16, most significant digit first
  assign pp = {4'd0, ua} * {64'd0, ub[63 -: MUL_DIGIT]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        ua  <= a[63] ? 64'(-a) : 64'(a);
        ub  <= b[63] ? 64'(-b) : 64'(b);
        neg <= a[63] ^ b[63];
        acc <= '0;
      end else if (run) begin
        acc <= (acc << MUL_DIGIT) + {60'd0, pp};
        ub  <= ub << MUL_DIGIT;
        cnt <= cnt + 4'd1;
        if (cnt == 4'(MUL_STEPS - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        prod <= neg ? -signed'(acc) : signed'(acc);
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/tcm_back.sv =====
`timescale 1ns / 1ps
module tcm_back import tcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  item_t              q_item,
  output logic               q_pop,
  input  logic [31:0]        density,
  output logic               strobe,
  output logic [3:0]         row,
  output logic [3:0]         col,
  output logic signed [63:0] mass_value,
  output logic               last_entry
);

  back_state_t state, state_next;
  phase_t      phase;
  item_t       item;

  logic [1:0]  p, d, c;
  logic [3:0]  step;
  logic [5:0]  e;
  logic [3:0]  ri, cj;

  logic [JAC_DEPTH-1:0]    jvalid;
  logic signed [JAC_W-1:0] jac [JAC_DEPTH];
  logic signed [JAC_W-1:0] rdata, jnew;
  logic                    rd_ok;
  logic [JAC_AW-1:0]       raddr, jaddr_acc, pbase;
  logic                    jac_we;

  logic signed [PROD_W-1:0]      jprod, jterm;
  logic signed [COORD_WIDTH-1:0] coord_sel;
  logic signed [63:0]            rd_val;

  logic signed [63:0]  opa, opb, sum;
  logic signed [127:0] acc, prod;
  logic signed [63:0]  minor [3];
  logic signed [63:0]  dets [POINTS];
  logic                mul_start, mul_done;
  det_step_t           ds;
  acc_op_t             op;

  tcm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .prod  (prod)
  );

  assign ds        = det_step(step);
  assign pbase     = JAC_AW'(p) * JAC_AW'(PT_STRIDE);
  assign jaddr_acc = pbase + JAC_AW'(d) * JAC_AW'(3) + JAC_AW'(c);
  assign rd_val    = rd_ok ? 64'(rdata) : 64'sd0;
  assign jterm     = (jprod + PROD_W'(64'sd1 <<< (FRAC - 1))) >>> FRAC;
  assign jnew      = rd_val[JAC_W-1:0] + JAC_W'(jterm);

  always_comb begin
    case (c)
      2'd0:    coord_sel = item.x;
      2'd1:    coord_sel = item.y;
      default: coord_sel = item.z;
    endcase
  end

  always_comb begin
    case (phase)
      PH_DET:  op = ds.op;
      PH_SUM:  op = (p == 2'd0) ? OP_LOAD : OP_ADD;
      default: op = OP_LOAD;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_item.node_ok) begin
            state_next = B_ACC_RD;
          end else if (q_item.last) begin
            state_next = B_RD_A;
          end
        end
      end
      B_ACC_RD: state_next = B_ACC_WR;
      B_ACC_WR: begin
        if (p == 2'(POINTS - 1) && d == 2'd2 && c == 2'd2) begin
          state_next = item.last ? B_RD_A : B_IDLE;
        end else begin
          state_next = B_ACC_RD;
        end
      end
      B_RD_A:  state_next = B_RD_B;
      B_RD_B:  state_next = B_OPS;
      B_OPS:   state_next = B_MUL;
      B_MUL:   state_next = B_WAIT;
      B_WAIT:  state_next = mul_done ? B_ACCUM : B_WAIT;
      B_ACCUM: begin
        case (phase)
          PH_DET:  state_next = (ds.fin != FIN_NONE) ? B_FIN : B_RD_A;
          PH_SUM:  state_next = (p == 2'(POINTS - 1)) ? B_FIN : B_OPS;
          default: state_next = B_FIN;
        endcase
      end
      B_FIN: begin
        case (phase)
          PH_DET: begin
            if (step == 4'(DET_STEPS - 1) && p == 2'(POINTS - 1)) begin
              state_next = B_OPS;
            end else begin
              state_next = B_RD_A;
            end
          end
          PH_SUM:  state_next = B_OPS;
          default: state_next = (e == 6'(ENTRIES - 1)) ? B_IDLE : B_OPS;
        endcase
      end
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = (state == B_IDLE) && !q_empty;
    mul_start = (state == B_MUL);
    jac_we    = (state == B_ACC_WR);
    case (state)
      B_RD_A:  raddr = pbase + {2'd0, ds.a_idx};
      B_RD_B:  raddr = pbase + {2'd0, ds.b_idx};
      default: raddr = jaddr_acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (jac_we) begin
      jac[jaddr_acc] <= jnew;
    end
    rdata <= jac[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      phase      <= PH_DET;
      jvalid     <= '0;
      strobe     <= 1'b0;
      last_entry <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      rd_ok  <= jvalid[raddr];
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            item  <= q_item;
            p     <= '0;
            d     <= '0;
            c     <= '0;
            step  <= '0;
            phase <= PH_DET;
          end
        end
        B_ACC_RD: begin
          jprod <= PROD_W'(signed'(DSH[p][d][item.node])) * PROD_W'(coord_sel);
        end
        B_ACC_WR: begin
          jvalid[jaddr_acc] <= 1'b1;
          if (c == 2'd2) begin
            c <= '0;
            if (d == 2'd2) begin
              d <= '0;
              p <= p + 2'd1;
            end else begin
              d <= d + 2'd1;
            end
          end else begin
            c <= c + 2'd1;
          end
        end
        B_RD_B: opa <= rd_val;
        B_OPS: begin
          case (phase)
            PH_DET: opb <= ds.b_minor ? minor[ds.b_idx[1:0]] : rd_val;
            PH_SUM: begin
              opa <= dets[p];
              opb <= 64'(signed'(KTAB[e][p]));
            end
            default: begin
              opa <= sum;
              opb <= {32'd0, density};
            end
          endcase
        end
        B_ACCUM: begin
          case (op)
            OP_LOAD: acc <= prod;
            OP_ADD:  acc <= acc + prod;
            OP_SUB:  acc <= acc - prod;
            default: acc <= prod;
          endcase
          if (phase == PH_DET && ds.fin == FIN_NONE) begin
            step <= step + 4'd1;
          end
          if (phase == PH_SUM && p != 2'(POINTS - 1)) begin
            p <= p + 2'd1;
          end
        end
        B_FIN: begin
          case (phase)
            PH_DET: begin
              if (ds.fin == FIN_MINOR) begin
                minor[step[2:1]] <= rsat(acc, 16);
              end else begin
                dets[p] <= rsat(acc, 8);
              end
              if (step == 4'(DET_STEPS - 1)) begin
                step <= '0;
                if (p == 2'(POINTS - 1)) begin
                  phase <= PH_SUM;
                  p     <= '0;
                  e     <= '0;
                  ri    <= '0;
                  cj    <= '0;
                end else begin
                  p <= p + 2'd1;
                end
              end else begin
                step <= step + 4'd1;
              end
            end
            PH_SUM: begin
              sum   <= rsat(acc, 40);
              phase <= PH_DENS;
            end
            default: begin
              strobe     <= 1'b1;
              row        <= ri;
              col        <= cj;
              mass_value <= rsat(acc, 16);
              last_entry <= (e == 6'(ENTRIES - 1));
              phase      <= PH_SUM;
              p          <= '0;
              if (e == 6'(ENTRIES - 1)) begin
                jvalid <= '0;
                phase  <= PH_DET;
              end else begin
                e <= e + 6'd1;
                if (cj == 4'(NODES - 1)) begin
                  ri <= ri + 4'd1;
                  cj <= ri + 4'd1;
                end else begin
                  cj <= cj + 4'd1;
                end
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    strobe && last_entry |-> state == B_IDLE && jvalid == '0)
    else $error("final entry without return to idle and cleared sums");
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("back-to-back result strobes");
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == B_WAIT)
    else $error("multiplier finished outside wait state");
  a_upper_tri: assert property (@(posedge clk) disable iff (rst)
    strobe |-> col >= row && col < 4'(NODES))
    else $error("entry index outside upper triangle");
`endif

endmodule

// ===== hdl/tet10_consistent_mass_matrix.sv =====
`timescale 1ns / 1ps
// Consistent mass matrix of a ten-node tetrahedron, 4-point rule. Node items are
// transferred when start is high and busy is low; a two-entry queue sits in front of
// the compute engine, so busy rises only when two items are waiting. Each node item is
// taken from the queue, then makes 36 Jacobian updates, each a read and a write through
// the single-port Jacobian memory. The item marked last then runs 311 products through
// one shared radix-16 64x64 multiplier: determinants for the four points first, then the
// mass entries one after another, 55 entries, each a sum of four products over the
// points scaled by density. Results carry no backpressure: each entry is valid for
// exactly one cycle while strobe is high, and last_entry marks the 55th.
// Density may be written only while no element is in flight.
module tet10_consistent_mass_matrix import tcm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    node_index,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_z,
  input  logic                          last_node,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [31:0]                   cfg_data,
  output logic                          strobe,
  output logic [3:0]                    row,
  output logic [3:0]                    col,
  output logic signed [63:0]            mass_value,
  output logic                          last_entry
);

  logic [31:0] density;
  item_t       din, q_item;
  logic        push, full, empty, pop;

  assign cfg_ready = 1'b1;
  assign busy      = full;

  // out-of-range node adds nothing; drop it unless it closes the element
  assign din.node_ok = (node_index < 4'(NODES));
  assign din.node    = node_index;
  assign din.x       = coord_x;
  assign din.y       = coord_y;
  assign din.z       = coord_z;
  assign din.last    = last_node;
  assign push        = start && !busy && (din.node_ok || last_node);

  always_ff @(posedge clk) begin
    if (rst) begin
      density <= DENSITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      density <= cfg_data;
    end
  end

  tcm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (din),
    .pop   (pop),
    .dout  (q_item),
    .full  (full),
    .empty (empty)
  );

  tcm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (empty),
    .q_item     (q_item),
    .q_pop      (pop),
    .density    (density),
    .strobe     (strobe),
    .row        (row),
    .col        (col),
    .mass_value (mass_value),
    .last_entry (last_entry)
  );

endmodule

// ===== tb/tb_tet10_consistent_mass_matrix.sv =====
`timescale 1ns / 1ps
module tb_tet10_consistent_mass_matrix;
  import tcm_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int DIR_ROWS = 24;

  typedef struct {
    logic [3:0]                    node;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          last;
    logic                          known_zero;
  } stim_row_t;

  typedef struct {
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [63:0] mass;
    logic               last;
  } mass_entry_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [3:0]                    node_index = '0;
  logic signed [COORD_WIDTH-1:0] coord_x = '0;
  logic signed [COORD_WIDTH-1:0] coord_y = '0;
  logic signed [COORD_WIDTH-1:0] coord_z = '0;
  logic                          last_node = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [31:0]                   cfg_data = '0;
  logic                          strobe;
  logic [3:0]                    row;
  logic [3:0]                    col;
  logic signed [63:0]            mass_value;
  logic                          last_entry;

  tet10_consistent_mass_matrix i_dut (
    .clk, .rst, .start, .busy, .node_index, .coord_x, .coord_y, .coord_z, .last_node,
    .cfg_valid, .cfg_ready, .cfg_data, .strobe, .row, .col, .mass_value, .last_entry
  );

  always #10 clk = ~clk;

  longint      dshape_q28 [POINTS][3][NODES];
  longint      nn_q40 [POINTS][NODES][NODES];
  logic [47:0] jac_acc [36];
  logic [31:0] density_q16 = DENSITY_RESET;
  mass_entry_t mass_expect_q [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          items_sent = 0;
  int          elements_done = 0;
  int          entries_checked = 0;
  int          density_writes = 0;

  function automatic longint qm28(longint a, longint b);
    return (a * b + (longint'(1) <<< 27)) >>> 28;
  endfunction

  function automatic void build_shape_tables();
    longint unsigned f15;
    longint one, qa, qb, r, s, u, l1, l2, l3, l4, prod, mag, q;
    longint nv [NODES];
    f15 = 64'd30517578125;
    one = longint'(1) <<< 28;
    qa = longint'((64'd585410196627215 * 64'd8192 + f15 / 2) / f15);
    qb = longint'((64'd138196601125011 * 64'd8192 + f15 / 2) / f15);
    for (int p = 0; p < POINTS; p++) begin
      r = (p == 0) ? qa : qb;
      s = (p == 1) ? qa : qb;
      u = (p == 2) ? qa : qb;
      l1 = one - r - s - u;
      l2 = r;
      l3 = s;
      l4 = u;
      for (int d = 0; d < 3; d++)
        for (int n = 0; n < NODES; n++) dshape_q28[p][d][n] = 0;
      dshape_q28[p][0][0] = one - 4 * l1;
      dshape_q28[p][1][0] = one - 4 * l1;
      dshape_q28[p][2][0] = one - 4 * l1;
      dshape_q28[p][0][1] = 4 * l2 - one;
      dshape_q28[p][1][2] = 4 * l3 - one;
      dshape_q28[p][2][3] = 4 * l4 - one;
      dshape_q28[p][0][4] = 4 * (l1 - l2);
      dshape_q28[p][1][4] = -4 * l2;
      dshape_q28[p][2][4] = -4 * l2;
      dshape_q28[p][0][5] = 4 * l3;
      dshape_q28[p][1][5] = 4 * l2;
      dshape_q28[p][0][6] = -4 * l3;
      dshape_q28[p][1][6] = 4 * (l1 - l3);  // edge 2-0 node, by s
      dshape_q28[p][2][6] = -4 * l3;
      dshape_q28[p][0][7] = -4 * l4;
      dshape_q28[p][1][7] = -4 * l4;
      dshape_q28[p][2][7] = 4 * (l1 - l4);
      dshape_q28[p][0][8] = 4 * l4;
      dshape_q28[p][2][8] = 4 * l2;
      dshape_q28[p][1][9] = 4 * l4;
      dshape_q28[p][2][9] = 4 * l3;
      nv[0] = qm28(l1, 2 * l1 - one);
      nv[1] = qm28(l2, 2 * l2 - one);
      nv[2] = qm28(l3, 2 * l3 - one);
      nv[3] = qm28(l4, 2 * l4 - one);
      nv[4] = qm28(4 * l1, l2);
      nv[5] = qm28(4 * l2, l3);
      nv[6] = qm28(4 * l3, l1);
      nv[7] = qm28(4 * l1, l4);
      nv[8] = qm28(4 * l2, l4);
      nv[9] = qm28(4 * l3, l4);
      for (int i = 0; i < NODES; i++)
        for (int j = 0; j < NODES; j++) begin
          prod = nv[i] * nv[j];
          mag = (prod < 0) ? -prod : prod;
          q = (mag + 786432) / 1572864;
          nn_q40[p][i][j] = (prod < 0) ? -q : q;
        end
    end
  endfunction

  function automatic logic signed [63:0] round_sat(logic signed [127:0] v, int n);
    logic signed [127:0] t;
    t = (v + (128'sd1 <<< (n - 1))) >>> n;
    if (t[127:63] == '0 || t[127:63] == '1) return t[63:0];
    return t[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic logic signed [127:0] jac_at(int p, int d, int c);
    logic [47:0] v;
    v = jac_acc[p * 9 + d * 3 + c];
    return $signed({{80{v[47]}}, v});
  endfunction

  function automatic logic signed [63:0] minor2(int p, int r0, int r1, int c0, int c1);
    return round_sat(jac_at(p, r0, c0) * jac_at(p, r1, c1)
                     - jac_at(p, r0, c1) * jac_at(p, r1, c0), 16);
  endfunction

  function automatic void predict_item(stim_row_t it);
    longint xyz [3];
    longint term;
    logic signed [63:0] det [POINTS];
    logic signed [127:0] acc;
    logic signed [127:0] dens;
    logic signed [63:0] s;
    mass_entry_t e;
    int n;
    xyz[0] = longint'(it.x);
    xyz[1] = longint'(it.y);
    xyz[2] = longint'(it.z);
    if (it.node < NODES) begin
      for (int p = 0; p < POINTS; p++)
        for (int d = 0; d < 3; d++)
          for (int c = 0; c < 3; c++) begin
            term = (dshape_q28[p][d][it.node] * xyz[c] + (longint'(1) <<< 27)) >>> 28;
            jac_acc[p * 9 + d * 3 + c] = jac_acc[p * 9 + d * 3 + c] + term[47:0];
          end
    end
    if (!it.last) return;
    for (int p = 0; p < POINTS; p++) begin
      acc = jac_at(p, 0, 0) * 128'(minor2(p, 1, 2, 1, 2))
          - jac_at(p, 0, 1) * 128'(minor2(p, 1, 2, 0, 2))
          + jac_at(p, 0, 2) * 128'(minor2(p, 1, 2, 0, 1));
      det[p] = round_sat(acc, 8);
    end
    dens = $signed({96'd0, density_q16});
    n = 0;
    for (int i = 0; i < NODES; i++)
      for (int j = i; j < NODES; j++) begin
        acc = '0;
        for (int p = 0; p < POINTS; p++)
          acc = acc + 128'(det[p]) * 128'(nn_q40[p][i][j]);
        s = round_sat(acc, 40);
        e.row = 4'(i);
        e.col = 4'(j);
        e.mass = it.known_zero ? 64'sd0 : round_sat(128'(s) * dens, 16);
        e.last = (n == ENTRIES - 1);
        mass_expect_q.push_back(e);
        n++;
      end
    for (int k = 0; k < 36; k++) jac_acc[k] = '0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** tet10_consistent_mass_matrix: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    mass_entry_t e;
    if (!rst && strobe) begin
      if (mass_expect_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected entry row=%0d col=%0d mass=%0d", row, col, mass_value);
      end else begin
        e = mass_expect_q.pop_front();
        entries_checked <= entries_checked + 1;
        if (row !== e.row || col !== e.col || mass_value !== e.mass ||
            last_entry !== e.last) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp (%0d,%0d) %0d last=%0b, got (%0d,%0d) %0d last=%0b",
                     e.row, e.col, e.mass, e.last, row, col, mass_value, last_entry);
        end
      end
    end
  end

  int burst_left = 0;

  // drive one node item and hold it until transferred
  task automatic send_node(stim_row_t it);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start <= 1'b1;
    node_index <= it.node;
    coord_x <= it.x;
    coord_y <= it.y;
    coord_z <= it.z;
    last_node <= it.last;
    do @(posedge clk); while (busy);
    predict_item(it);
    items_sent++;
    if (it.last) elements_done++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    while (mass_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_density(logic [31:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    density_q16 = v;
    density_writes++;
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    return COORD_WIDTH'($urandom);
  endfunction

  // shape: mostly proper elements, some full-range noise, some unterminated
  task automatic send_element(int kind);
    stim_row_t it;
    int order [NODES];
    int tmp, k, cnt, span, ox, oy, oz, hx, hy, hz;
    for (int n = 0; n < NODES; n++) order[n] = n;
    for (int n = NODES - 1; n > 0; n--) begin
      k = $urandom_range(0, n);
      tmp = order[n];
      order[n] = order[k];
      order[k] = tmp;
    end
    it.known_zero = 1'b0;
    if (kind < 7) begin
      span = $urandom_range(1 << 10, 1 << 22);
      ox = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      oy = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      oz = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      for (int n = 0; n < NODES; n++) begin
        k = order[n];
        hx = (k == 1) ? 2 : (k == 4 || k == 5 || k == 8) ? 1 : 0;
        hy = (k == 2) ? 2 : (k == 5 || k == 6 || k == 9) ? 1 : 0;
        hz = (k == 3) ? 2 : (k == 7 || k == 8 || k == 9) ? 1 : 0;
        it.node = 4'(k);
        it.x = COORD_WIDTH'(ox + hx * (span / 2) + $signed($urandom_range(0, span / 8))
                            - span / 16);
        it.y = COORD_WIDTH'(oy + hy * (span / 2) + $signed($urandom_range(0, span / 8))
                            - span / 16);
        it.z = COORD_WIDTH'(oz + hz * (span / 2) + $signed($urandom_range(0, span / 8))
                            - span / 16);
        it.last = (n == NODES - 1);
        send_node(it);
      end
    end else begin
      cnt = $urandom_range(1, 12);
      for (int n = 0; n < cnt; n++) begin
        it.node = 4'($urandom_range(0, 15));
        it.x = rand_coord();
        it.y = rand_coord();
        it.z = rand_coord();
        it.last = (kind == 9) ? 1'b0 : (n == cnt - 1);
        send_node(it);
      end
    end
  endtask

  stim_row_t dir_tab [DIR_ROWS];
  logic [31:0] dens_set [5];

  initial begin
    stim_row_t it;
    int el;
    logic ended;
    build_shape_tables();
    for (int k = 0; k < 36; k++) jac_acc[k] = '0;
    // out-of-range node with last right after reset: all-zero matrix
    dir_tab[0] = '{4'd15, 24'sd65536, -24'sd65536, 24'sd1, 1'b1, 1'b1};
    // unit reference element, vertices then edge nodes
    dir_tab[1] = '{4'd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0};
    dir_tab[2] = '{4'd1, 24'sd65536, 24'sd0, 24'sd0, 1'b0, 1'b0};
    dir_tab[3] = '{4'd2, 24'sd0, 24'sd65536, 24'sd0, 1'b0, 1'b0};
    dir_tab[4] = '{4'd3, 24'sd0, 24'sd0, 24'sd65536, 1'b0, 1'b0};
    dir_tab[5] = '{4'd4, 24'sd32768, 24'sd0, 24'sd0, 1'b0, 1'b0};
    dir_tab[6] = '{4'd5, 24'sd32768, 24'sd32768, 24'sd0, 1'b0, 1'b0};
    dir_tab[7] = '{4'd6, 24'sd0, 24'sd32768, 24'sd0, 1'b0, 1'b0};
    dir_tab[8] = '{4'd7, 24'sd0, 24'sd0, 24'sd32768, 1'b0, 1'b0};
    dir_tab[9] = '{4'd8, 24'sd32768, 24'sd0, 24'sd32768, 1'b0, 1'b0};
    dir_tab[10] = '{4'd9, 24'sd0, 24'sd32768, 24'sd32768, 1'b1, 1'b0};
    // single node loaded, rest never loaded: degenerate, only rounding survives
    dir_tab[11] = '{4'd6, 24'sd8388607, -24'sd8388608, 24'sd8388607, 1'b1, 1'b0};
    // extremes, repeated node, an out-of-range node
    dir_tab[12] = '{4'd1, 24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b0, 1'b0};
    dir_tab[13] = '{4'd2, -24'sd8388608, -24'sd8388608, -24'sd8388608, 1'b0, 1'b0};
    dir_tab[14] = '{4'd3, 24'sd8388607, -24'sd8388608, 24'sd8388607, 1'b0, 1'b0};
    dir_tab[15] = '{4'd0, -24'sd8388608, 24'sd8388607, -24'sd1, 1'b0, 1'b0};
    dir_tab[16] = '{4'd10, 24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b0, 1'b0};
    dir_tab[17] = '{4'd6, 24'sd8388607, 24'sd0, -24'sd8388608, 1'b0, 1'b0};
    dir_tab[18] = '{4'd6, 24'sd8388607, 24'sd0, -24'sd8388608, 1'b0, 1'b0};
    dir_tab[19] = '{4'd9, -24'sd1, -24'sd1, -24'sd1, 1'b1, 1'b0};
    // edge 2-0 node with two vertices, closed by an out-of-range node with last
    dir_tab[20] = '{4'd2, 24'sd0, 24'sd131072, 24'sd0, 1'b0, 1'b0};
    dir_tab[21] = '{4'd6, 24'sd0, 24'sd65536, 24'sd0, 1'b0, 1'b0};
    dir_tab[22] = '{4'd1, 24'sd131072, 24'sd0, 24'sd0, 1'b0, 1'b0};
    dir_tab[23] = '{4'd12, 24'sd0, 24'sd0, 24'sd131072, 1'b1, 1'b0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) send_node(dir_tab[r]);

    dens_set[0] = 32'hFFFF_FFFF;
    dens_set[1] = 32'd0;
    dens_set[2] = 32'd65536;
    dens_set[3] = 32'd7 << 16;
    dens_set[4] = 32'd1;
    el = 0;
    ended = 1'b1;
    while (items_sent < 210) begin
      if (ended && el % 3 == 0)
        write_density((el / 3 < 5) ? dens_set[el / 3] : $urandom);
      send_element($urandom_range(0, 9));
      ended = last_node;
      el++;
    end
    if (!ended) begin
      it = '{4'd0, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0};
      send_node(it);
    end
    wait_idle();

    $display("%0d node items in %0d elements, %0d entries checked, %0d density writes",
             items_sent, elements_done, entries_checked, density_writes);
    if (mismatches == 0 && mass_expect_q.size() == 0) begin
      $display("** tet10_consistent_mass_matrix: PASSED **");
    end else begin
      $display("%0d mismatches, %0d entries missing", mismatches, mass_expect_q.size());
      $display("** tet10_consistent_mass_matrix: FAILED **");
    end
    $finish;
  end

endmodule
